[rtl/psb_pkg.sv]
// Package for the positional sequence buffer.
// Holds the request and result types, field widths, request and status codes.
// No dependencies.
`default_nettype none

package psb_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int LEN_W = 5;
	localparam int IDX_W = $clog2(DEPTH);

	localparam logic [1:0] REQ_READ   = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [LEN_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic [LEN_W-1:0]        length;
		logic [1:0]              status;
	} rsp_t;

	// what every cell of the row does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic signed [VAL_W-1:0] new_value;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/psb_cell.sv]
// One storage cell of the sequence row.
// Depends on psb_pkg for the control struct and widths.
`default_nettype none

module psb_cell (
	input  wire logic                          clk,
	input  wire psb_pkg::cell_ctl_t            ctl,
	input  wire logic                          sel,
	input  wire logic                          after_in,
	output logic                               after_out,
	input  wire logic signed [psb_pkg::VAL_W-1:0] left_val,
	input  wire logic signed [psb_pkg::VAL_W-1:0] right_val,
	output logic signed [psb_pkg::VAL_W-1:0]   val
);

	logic signed [psb_pkg::VAL_W-1:0] entry_q;
	logic signed [psb_pkg::VAL_W-1:0] entry_d;

	// high from the addressed cell onward
	assign after_out = after_in | sel;
	assign val       = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			psb_pkg::CELL_INSERT: begin
				if (after_in) begin
					entry_d = left_val;
				end else if (sel) begin
					entry_d = ctl.new_value;
				end
			end
			psb_pkg::CELL_REMOVE: begin
				if (after_in | sel) begin
					entry_d = right_val;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

[rtl/positional_sequence_buffer.sv]
// Top level of the positional sequence buffer: decode, length counter, cell row.
// Depends on psb_pkg and psb_cell.
`default_nettype none

// Usage
//   Request channel: drive request and raise start; the request is taken at
//   the rising edge where start is high and busy is low. busy never rises,
//   so a request can be taken every cycle.
//   Result channel: done pulses for exactly one cycle, in the cycle after the
//   request was taken, with result holding the value read or removed, the
//   length after the request and a status code. There is no back-pressure:
//   the receiver must take each result in the cycle it is shown.
//   Throughput is one request per cycle. It is set by the cell row: the
//   cells at and behind the addressed one update in parallel in the same
//   cycle, and a read is a single mux over the cells.
//   A bad position or an insert into a full buffer only reports a status;
//   the stored sequence and length stay as they were. Request type 3 does
//   nothing and reports ok.
//   Reset clears the length to zero and drops any pending result. Cell
//   contents are not reset; only entries below the length are ever read.
module positional_sequence_buffer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire psb_pkg::req_t   request,
	output logic                 done,
	output psb_pkg::rsp_t        result
);

	localparam logic [psb_pkg::LEN_W-1:0] FULL_LEN = psb_pkg::LEN_W'(psb_pkg::DEPTH);

	logic [psb_pkg::LEN_W-1:0] count_q;
	logic [psb_pkg::LEN_W-1:0] count_d;
	logic                      done_q;
	psb_pkg::rsp_t             rsp_q;
	psb_pkg::rsp_t             rsp_d;
	psb_pkg::cell_ctl_t        ctl;

	logic                      accept;
	logic                      pos_lt;
	logic                      pos_le;
	logic                      full;

	logic [psb_pkg::DEPTH-1:0] sel;
	logic [psb_pkg::DEPTH:0]   after_c;
	logic signed [psb_pkg::VAL_W-1:0] cell_val [psb_pkg::DEPTH];
	logic signed [psb_pkg::VAL_W-1:0] rd_val;

	// no request ever stalls, so busy is tied low
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign pos_lt = request.position < count_q;
	assign pos_le = request.position <= count_q;
	assign full   = count_q == FULL_LEN;
	assign rd_val = cell_val[request.position[psb_pkg::IDX_W-1:0]];

	// one-hot position decode; positions past the row select no cell
	always_comb begin
		for (int i = 0; i < psb_pkg::DEPTH; i++) begin
			sel[i] = request.position == psb_pkg::LEN_W'(i);
		end
	end

	// request decode: status, returned value, next length, cell command
	always_comb begin
		count_d          = count_q;
		ctl.op           = psb_pkg::CELL_HOLD;
		ctl.new_value    = request.value;
		rsp_d.item_value = '0;
		rsp_d.status     = psb_pkg::ST_OK;
		unique case (request.req_type)
			psb_pkg::REQ_READ: begin
				if (pos_lt) begin
					rsp_d.item_value = rd_val;
				end else begin
					rsp_d.status = psb_pkg::ST_BAD_POS;
				end
			end
			psb_pkg::REQ_INSERT: begin
				if (!pos_le) begin
					rsp_d.status = psb_pkg::ST_BAD_POS;
				end else if (full) begin
					rsp_d.status = psb_pkg::ST_FULL;
				end else begin
					ctl.op  = accept ? psb_pkg::CELL_INSERT : psb_pkg::CELL_HOLD;
					count_d = count_q + 1'b1;
				end
			end
			psb_pkg::REQ_REMOVE: begin
				if (pos_lt) begin
					rsp_d.item_value = rd_val;
					ctl.op  = accept ? psb_pkg::CELL_REMOVE : psb_pkg::CELL_HOLD;
					count_d = count_q - 1'b1;
				end else begin
					rsp_d.status = psb_pkg::ST_BAD_POS;
				end
			end
			default: begin
				// unused request type: no effect
				rsp_d.status = psb_pkg::ST_OK;
			end
		endcase
		rsp_d.length = count_d;
	end

	// the row: after_c[i] is high for cells behind the addressed one
	assign after_c[0] = 1'b0;

	for (genvar g = 0; g < psb_pkg::DEPTH; g++) begin : g_cell
		logic signed [psb_pkg::VAL_W-1:0] left_v;
		logic signed [psb_pkg::VAL_W-1:0] right_v;

		// row ends: front cell never takes from the left, last cell's
		// right neighbor lies past the length and is never read
		if (g == 0) begin : g_front
			assign left_v = request.value;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == psb_pkg::DEPTH-1) begin : g_back
			assign right_v = cell_val[g];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end

		psb_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.sel       (sel[g]),
			.after_in  (after_c[g]),
			.after_out (after_c[g+1]),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

[rtl/psb_checker.sv]
// Port-level checks for the positional sequence buffer, bound to the top level.
// Depends on psb_pkg and positional_sequence_buffer.
`default_nettype none

module psb_assertions (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire psb_pkg::req_t request,
	input wire logic          done,
	input wire psb_pkg::rsp_t result
);

	localparam logic [psb_pkg::LEN_W-1:0] FULL_LEN = psb_pkg::LEN_W'(psb_pkg::DEPTH);

	// one result per taken request, in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken request gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a request");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.length <= FULL_LEN))
		else $error("length beyond depth");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == psb_pkg::ST_FULL) |-> (result.length == FULL_LEN))
		else $error("full status with room left");

	a_insert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.req_type == psb_pkg::REQ_INSERT)
		|=> (result.item_value == '0))
		else $error("insert returned a value");

endmodule

bind positional_sequence_buffer psb_assertions u_psb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

`default_nettype wire
